/* src/sfl_pkg.sv */
`default_nettype none
package sfl_pkg;

  localparam logic [1:0] MODE_NEGATIVE  = 2'd0;
  localparam logic [1:0] MODE_BLUR      = 2'd1;
  localparam logic [1:0] MODE_LAPLACIAN = 2'd2;
  localparam logic [1:0] MODE_SHARPEN   = 2'd3;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;
  localparam logic [1:0] REG_MAXVAL = 2'd3;

  localparam int SUM_W = 12;

  typedef struct packed {
    logic capture;
    logic read;
    logic update;
    logic calc;
    logic div_step;
    logic out_load;
  } sfl_cmd_t;

  typedef struct packed {
    logic ignore;
    logic active;
    logic use_div;
    logic div_done;
    logic out_free;
  } sfl_status_t;

endpackage
`default_nettype wire

/* src/sfl_if.sv */
`default_nettype none
interface sfl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] pixel_in;
  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink (input valid, input kind, input pixel_in, output ready);
endinterface

interface sfl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic       frame_end;
  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

interface sfl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* src/sfl_ctrl.sv */
`default_nettype none
module sfl_ctrl
  import sfl_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  sfl_status_t status,
  output sfl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_READ;
      end
      S_READ: begin
        cmd.read = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (status.ignore) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.update = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (!status.active) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.calc = 1'b1;
          state_nxt = status.use_div ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

/* src/sfl_datapath.sv */
`default_nettype none
module sfl_datapath
  import sfl_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  sfl_in_if.sink      in_ch,
  sfl_out_if.source   out_ch,
  sfl_cfg_if.sink     cfg_ch,
  input  sfl_cmd_t    cmd,
  output sfl_status_t status
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 2) + 1;
  localparam int RW = $clog2(MAX_HEIGHT + 2) + 1;
  localparam int DIV_STEPS = SUM_W;
  localparam int DC_W = $clog2(DIV_STEPS + 1);

  logic [1:0]  mode_r;
  logic [10:0] width_r, height_r;
  logic [7:0]  maxval_r;

  logic [CW-1:0] w_eff;
  logic [RW-1:0] h_eff;

  logic [7:0] line_prev [MAX_WIDTH];
  logic [7:0] line_curr [MAX_WIDTH];
  logic [7:0] prev_q_r, curr_q_r;

  logic [7:0] win_r [9];
  logic [CW-1:0] in_col_r, out_col_r;
  logic [RW-1:0] in_row_r, out_row_r;
  logic          kind_r, drain_r, active_r;
  logic [7:0]    px_r;

  logic [7:0]       res_r;
  logic [SUM_W-1:0] quo_r;
  logic [4:0]       rem_r;
  logic [3:0]       cnt_r;
  logic [DC_W-1:0]  dcnt_r;

  logic [7:0] out_pixel_r;
  logic       out_end_r, out_valid_r;

  logic [AW-1:0] col;
  logic          cfg_wr, restart, last;
  logic [8:0]    ok;
  logic [SUM_W-1:0] sum;
  logic [3:0]    cnt;
  logic signed [11:0] acc;
  logic [7:0]    lap_v, neg_v;
  logic [4:0]    rem_sh;

  assign w_eff = (width_r == 11'd0) ? CW'(1) :
                 (32'(width_r) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_r);
  assign h_eff = (height_r == 11'd0) ? RW'(1) :
                 (32'(height_r) > MAX_HEIGHT) ? RW'(MAX_HEIGHT) : RW'(height_r);

  assign col = in_col_r[AW-1:0];
  assign cfg_wr = cfg_ch.valid && cfg_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign last = (out_row_r + RW'(1) >= h_eff) && (out_col_r + CW'(1) >= w_eff);
  assign restart = cfg_wr && (cfg_ch.index == REG_WIDTH || cfg_ch.index == REG_HEIGHT);

  always_comb begin
    logic rv0, rv2, cv0, cv2;
    rv0 = (out_row_r >= RW'(1));
    rv2 = (out_row_r + RW'(1) < h_eff);
    cv0 = (out_col_r >= CW'(1));
    cv2 = (out_col_r + CW'(1) < w_eff);
    ok = {rv2 && cv2, rv2, rv2 && cv0, cv2, 1'b1, cv0, rv0 && cv2, rv0, rv0 && cv0};
    sum = '0;
    cnt = '0;
    for (int i = 0; i < 9; i++) begin
      if (ok[i]) begin
        sum = sum + SUM_W'(win_r[i]);
        cnt = cnt + 4'd1;
      end
    end
    acc = (mode_r == MODE_LAPLACIAN) ? $signed({2'b00, win_r[4], 2'b00})
                                     : $signed({2'b00, win_r[4], 2'b00}) + $signed({4'b0, win_r[4]});
    if (ok[1]) acc = acc - $signed({4'b0, win_r[1]});
    if (ok[3]) acc = acc - $signed({4'b0, win_r[3]});
    if (ok[5]) acc = acc - $signed({4'b0, win_r[5]});
    if (ok[7]) acc = acc - $signed({4'b0, win_r[7]});
    lap_v = (acc < 0) ? 8'd0 : (acc > 12'sd255) ? 8'd255 : acc[7:0];
    neg_v = (win_r[4] > maxval_r) ? 8'd0 : maxval_r - win_r[4];
    rem_sh = {rem_r[3:0], quo_r[SUM_W-1]};
  end

  assign status.ignore   = kind_r && !drain_r;
  assign status.active   = active_r;
  assign status.use_div  = (mode_r == MODE_BLUR);
  assign status.div_done = (dcnt_r == DC_W'(1));
  assign status.out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      prev_q_r <= line_prev[col];
      curr_q_r <= line_curr[col];
    end
    if (cmd.update) begin
      line_prev[col] <= curr_q_r;
      line_curr[col] <= px_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_ch.kind;
      px_r <= in_ch.pixel_in;
    end
    if (cmd.read && (in_row_r >= h_eff)) px_r <= 8'd0;
    if (cmd.calc) begin
      res_r <= (mode_r == MODE_NEGATIVE) ? neg_v : lap_v;
      quo_r <= sum;
      rem_r <= '0;
      cnt_r <= cnt;
      dcnt_r <= DC_W'(DIV_STEPS);
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, cnt_r}) begin
        rem_r <= rem_sh - {1'b0, cnt_r};
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - DC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_NEGATIVE;
      width_r <= 11'd1024;
      height_r <= 11'd1024;
      maxval_r <= 8'd255;
      drain_r <= 1'b0;
      active_r <= 1'b0;
      out_valid_r <= 1'b0;
      in_col_r <= '0;
      in_row_r <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      for (int i = 0; i < 9; i++) win_r[i] <= '0;
    end else begin
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          REG_MODE:   mode_r <= cfg_ch.data[1:0];
          REG_WIDTH:  width_r <= cfg_ch.data;
          REG_HEIGHT: height_r <= cfg_ch.data;
          REG_MAXVAL: maxval_r <= cfg_ch.data[7:0];
          default: ;
        endcase
      end
      if (cmd.read) drain_r <= (in_row_r >= h_eff);
      if (cmd.update) begin
        active_r <= (in_row_r >= RW'(2)) || (in_row_r == RW'(1) && in_col_r >= CW'(1));
      end
      if (cmd.out_load) begin
        out_pixel_r <= (mode_r == MODE_BLUR) ? quo_r[7:0] : res_r;
        out_end_r <= last;
      end
      if (restart || (cmd.out_load && last)) begin
        in_col_r <= '0;
        in_row_r <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        for (int i = 0; i < 9; i++) win_r[i] <= '0;
      end else begin
        if (cmd.update) begin
          win_r[0] <= win_r[1]; win_r[1] <= win_r[2];
          win_r[3] <= win_r[4]; win_r[4] <= win_r[5];
          win_r[6] <= win_r[7]; win_r[7] <= win_r[8];
          win_r[2] <= prev_q_r;
          win_r[5] <= curr_q_r;
          win_r[8] <= px_r;
          if (in_col_r + CW'(1) >= w_eff) begin
            in_col_r <= '0;
            in_row_r <= in_row_r + RW'(1);
          end else begin
            in_col_r <= in_col_r + CW'(1);
          end
        end
        if (cmd.out_load) begin
          if (out_col_r + CW'(1) >= w_eff) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + RW'(1);
          end else begin
            out_col_r <= out_col_r + CW'(1);
          end
        end
      end
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pixel_out = out_pixel_r;
  assign out_ch.frame_end = out_end_r;

endmodule
`default_nettype wire

/* src/stencil_3x3_image_filter_top.sv */
// Each accepted word is captured, its line buffer column read, the buffers and window
// updated and the result computed; box blur then runs the 12-step serial divider for
// the mean before the output is loaded. A new word is taken only once the last is
// through: each item reads and then writes the single-port line buffers before the
// window advances, and a result that waits for the output holds the next word back.
// Ignored words skip the update; words with no result skip the calculation.
// Reset: synchronous, active low; state and configuration registers return to their
// defaults, line buffers are not cleared and need no clearing pass.
`default_nettype none
module stencil_3x3_image_filter_top
  import sfl_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic clk,
  input  wire logic rst_n,
  sfl_in_if.sink    in_ch,
  sfl_out_if.source out_ch,
  sfl_cfg_if.sink   cfg_ch
);

  sfl_cmd_t    cmd;
  sfl_status_t status;
  logic        in_ready_ctrl;

  assign in_ch.ready = in_ready_ctrl;

  sfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready_ctrl),
    .status   (status),
    .cmd      (cmd)
  );

  sfl_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .status (status)
  );

endmodule
`default_nettype wire

/* sim/stencil_3x3_image_filter_top_tb.sv */
`timescale 1ns / 1ps
module stencil_3x3_image_filter_top_tb
  import sfl_pkg::*;
();

  localparam int LINE_MAX = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [7:0] pixel_out;
    logic       frame_end;
  } filt_word_t;

  class filter_scoreboard;
    logic [1:0]  mode;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [7:0]  max_val;
    logic [7:0]  prev_row [LINE_MAX];
    logic [7:0]  curr_row [LINE_MAX];
    logic [7:0]  win [9];
    int unsigned in_r, in_c, out_r, out_c;
    filt_word_t  pending [$];
    int          errors;
    int          checked;

    function new();
      mode = MODE_NEGATIVE;
      width_reg = 11'd1024;
      height_reg = 11'd1024;
      max_val = 8'd255;
      foreach (prev_row[i]) begin
        prev_row[i] = 8'd0;
        curr_row[i] = 8'd0;
      end
      restart();
      errors = 0;
      checked = 0;
    endfunction

    function void restart();
      foreach (win[i]) win[i] = 8'd0;
      in_r = 0;
      in_c = 0;
      out_r = 0;
      out_c = 0;
    endfunction

    function int unsigned eff(logic [10:0] v);
      if (v == 0) return 1;
      if (v > LINE_MAX) return LINE_MAX;
      return v;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] val);
      case (idx)
        REG_MODE: mode = val[1:0];
        REG_WIDTH: begin
          width_reg = val;
          restart();
        end
        REG_HEIGHT: begin
          height_reg = val;
          restart();
        end
        default: max_val = val[7:0];
      endcase
    endfunction

    function logic [7:0] filtered(int unsigned w, int unsigned h);
      bit ok [9];
      bit rv, cv;
      int unsigned sum, cnt;
      int acc;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          rv = (r == 0) ? (out_r >= 1) : (r == 2) ? (out_r + 1 < h) : 1'b1;
          cv = (c == 0) ? (out_c >= 1) : (c == 2) ? (out_c + 1 < w) : 1'b1;
          ok[r * 3 + c] = rv && cv;
        end
      end
      case (mode)
        MODE_NEGATIVE: return (win[4] > max_val) ? 8'd0 : max_val - win[4];
        MODE_BLUR: begin
          sum = 0;
          cnt = 0;
          for (int i = 0; i < 9; i++) begin
            if (ok[i]) begin
              sum += win[i];
              cnt++;
            end
          end
          return 8'(sum / cnt);
        end
        default: begin
          acc = int'(win[4]) * ((mode == MODE_LAPLACIAN) ? 4 : 5);
          if (ok[1]) acc -= win[1];
          if (ok[3]) acc -= win[3];
          if (ok[5]) acc -= win[5];
          if (ok[7]) acc -= win[7];
          if (acc < 0) return 8'd0;
          if (acc > 255) return 8'd255;
          return acc[7:0];
        end
      endcase
    endfunction

    function void note_input(logic kind, logic [7:0] pix);
      int unsigned w, h, col;
      bit drain, active, last;
      logic [7:0] px;
      filt_word_t res;
      w = eff(width_reg);
      h = eff(height_reg);
      drain = in_r >= h;
      if (kind && !drain) return;
      px = drain ? 8'd0 : pix;
      col = in_c % LINE_MAX;
      win[0] = win[1]; win[1] = win[2];
      win[3] = win[4]; win[4] = win[5];
      win[6] = win[7]; win[7] = win[8];
      win[2] = prev_row[col];
      win[5] = curr_row[col];
      win[8] = px;
      prev_row[col] = curr_row[col];
      curr_row[col] = px;
      active = (in_r >= 2) || (in_r == 1 && in_c >= 1);
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
      if (!active) return;
      last = (out_r + 1 >= h) && (out_c + 1 >= w);
      res.pixel_out = filtered(w, h);
      res.frame_end = last;
      pending.push_back(res);
      if (last) begin
        restart();
      end else begin
        out_c++;
        if (out_c >= w) begin
          out_c = 0;
          out_r++;
        end
      end
    endfunction

    function void report(string what);
      errors++;
      $display("MISMATCH %0t: %s", $realtime, what);
    endfunction

    function void check_word(logic [7:0] pix, logic fe);
      filt_word_t exp_w;
      checked++;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word pixel=%0d end=%0d", pix, fe));
        return;
      end
      exp_w = pending.pop_front();
      if (pix !== exp_w.pixel_out)
        report($sformatf("pixel_out %0d, wanted %0d", pix, exp_w.pixel_out));
      if (fe !== exp_w.frame_end)
        report($sformatf("frame_end %0d, wanted %0d", fe, exp_w.frame_end));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   quiet = 1'b0;
  int   cycles = 0;
  int   items = 0;
  int   frames = 0;
  filter_scoreboard sb;

  sfl_in_if  in_ch ();
  sfl_out_if out_ch ();
  sfl_cfg_if cfg_ch ();

  stencil_3x3_image_filter_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.pixel_in = 8'd0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_MODE;
    cfg_ch.data = 11'd0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= quiet || ($urandom_range(99) >= 14);
  end

  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.pixel_out, out_ch.frame_end);
  end

  task automatic send_word(logic kind, logic [7:0] pix);
    while (!quiet && $urandom_range(99) < 14) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= kind;
    in_ch.pixel_in <= pix;
    forever begin
      @(negedge clk);
      if (in_ch.ready) break;
    end
    sb.note_input(kind, pix);
    items++;
    @(posedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [10:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    forever begin
      @(negedge clk);
      if (cfg_ch.ready) break;
    end
    sb.write_reg(idx, val);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic setup(logic [1:0] md, logic [7:0] mx, logic [10:0] w, logic [10:0] h);
    write_cfg(REG_MODE, {9'($urandom_range(511)), md});
    write_cfg(REG_MAXVAL, {3'($urandom_range(7)), mx});
    write_cfg(REG_WIDTH, w);
    write_cfg(REG_HEIGHT, h);
  endtask

  // A pattern of 0 gives random pixels, 1 extremes, 2 all zero, 3 all full scale.
  task automatic run_frame(int pattern, bit noisy, bit cut_short);
    int unsigned w, h, n, stop;
    logic [7:0] px;
    w = sb.eff(sb.width_reg);
    h = sb.eff(sb.height_reg);
    n = w * h;
    stop = cut_short ? $urandom_range(((n > 64) ? 64 : n) - 1) : n;
    for (int unsigned i = 0; i < stop; i++) begin
      case (pattern)
        1: px = $urandom_range(1) ? 8'd255 : 8'd0;
        2: px = 8'd0;
        3: px = 8'd255;
        default: px = 8'($urandom_range(255));
      endcase
      if (noisy && $urandom_range(9) == 0) send_word(1'b1, 8'($urandom_range(255)));
      send_word(1'b0, px);
    end
    if (!cut_short) begin
      for (int unsigned i = 0; i <= w; i++)
        send_word((noisy && $urandom_range(3) == 0) ? 1'b0 : 1'b1, 8'($urandom_range(255)));
      frames++;
    end
    settle();
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);

    setup(MODE_NEGATIVE, 8'd255, 11'd3, 11'd3);
    run_frame(1, 1'b0, 1'b0);
    setup(MODE_NEGATIVE, 8'd1, 11'd3, 11'd3);
    run_frame(0, 1'b0, 1'b0);
    setup(MODE_BLUR, 8'd100, 11'd3, 11'd3);
    run_frame(3, 1'b0, 1'b0);
    setup(MODE_LAPLACIAN, 8'd255, 11'd3, 11'd3);
    run_frame(1, 1'b1, 1'b0);
    setup(MODE_SHARPEN, 8'd255, 11'd3, 11'd3);
    run_frame(1, 1'b1, 1'b0);
    setup(MODE_BLUR, 8'd255, 11'd0, 11'd1);
    run_frame(0, 1'b1, 1'b0);
    setup(MODE_BLUR, 8'd255, 11'd1, 11'd4);
    run_frame(0, 1'b0, 1'b0);
    setup(MODE_SHARPEN, 8'd255, 11'd4, 11'd0);
    run_frame(0, 1'b0, 1'b0);

    while (items < 560) begin
      quiet = (items > 250 && items < 400);
      setup(2'($urandom_range(3)), 8'($urandom_range(1, 255)),
            11'(($urandom_range(9) == 0) ? 2 : $urandom_range(1, 8)),
            11'($urandom_range(1, 6)));
      run_frame($urandom_range(4) == 0 ? $urandom_range(1, 3) : 0,
                $urandom_range(3) == 0, $urandom_range(7) == 0);
    end
    quiet = 1'b0;

    setup(MODE_LAPLACIAN, 8'd255, 11'd2047, 11'd1);
    run_frame(0, 1'b0, 1'b1);
    setup(MODE_BLUR, 8'd255, 11'd1024, 11'd3);
    run_frame(0, 1'b0, 1'b1);
    setup(MODE_NEGATIVE, 8'd128, 11'd1, 11'd2047);
    run_frame(0, 1'b0, 1'b1);

    settle();
    $display("Sent %0d words in %0d complete frames over all four modes and small sizes,",
             items, frames);
    $display("with part frames at the largest sizes; %0d words checked, %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* files.f */
src/sfl_pkg.sv
src/sfl_if.sv
src/sfl_ctrl.sv
src/sfl_datapath.sv
src/stencil_3x3_image_filter_top.sv
sim/stencil_3x3_image_filter_top_tb.sv
